// ===== hdl/cmr_pkg.sv =====
package cmr_pkg;

   localparam int ID_W     = 64;
   localparam int DATA_W   = 64;
   localparam int IDX_W    = 4;
   localparam int TOTAL_W  = 5;
   localparam int BYTES_W  = 4;
   localparam int STATUS_W = 3;
   localparam int CMD_W    = 2;
   localparam int OP_W     = 2;

   // Wide enough for a slot number of the largest table.
   localparam int SLOT_FIELD_W = 6;

   // A chunk index field can address this many chunks.
   localparam int INDEX_CHUNKS = 16;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_QUERY = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TAKE  = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK           = 3'd0;
   localparam logic [STATUS_W-1:0] ST_ZERO_TOTAL   = 3'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE        = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISMATCH     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL         = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND    = 3'd5;
   localparam logic [STATUS_W-1:0] ST_NOT_COMPLETE = 3'd6;

   // Work handed from the front to the back.
   localparam logic [OP_W-1:0] OP_RESP  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_TAKE  = 2'd2;

   typedef struct packed {
      logic [CMD_W-1:0]   command;
      logic [ID_W-1:0]    msg_id;
      logic [IDX_W-1:0]   chunk_index;
      logic [TOTAL_W-1:0] chunk_total;
      logic [DATA_W-1:0]  chunk_data;
      logic [BYTES_W-1:0] chunk_bytes;
   } cmr_item_type;

   typedef struct packed {
      logic [OP_W-1:0]         kind;
      logic [STATUS_W-1:0]     status;
      logic                    complete;
      logic [SLOT_FIELD_W-1:0] slot;
      logic [IDX_W-1:0]        index;
      logic [TOTAL_W-1:0]      total;
      logic [DATA_W-1:0]       data;
      logic [BYTES_W-1:0]      bytes;
   } cmr_op_type;

endpackage

// ===== hdl/cmr_ifs.sv =====
interface cmr_req_if import cmr_pkg::*;;
   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [ID_W-1:0]    msg_id;
   logic [IDX_W-1:0]   chunk_index;
   logic [TOTAL_W-1:0] chunk_total;
   logic [DATA_W-1:0]  chunk_data;
   logic [BYTES_W-1:0] chunk_bytes;

   modport source (
      output valid, command, msg_id, chunk_index, chunk_total, chunk_data, chunk_bytes,
      input  ready
   );
   modport sink (
      input  valid, command, msg_id, chunk_index, chunk_total, chunk_data, chunk_bytes,
      output ready
   );
endinterface

interface cmr_rsp_if import cmr_pkg::*;;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                complete;
   logic [DATA_W-1:0]   out_data;
   logic [BYTES_W-1:0]  out_bytes;
   logic                last;

   modport source (
      output valid, status, complete, out_data, out_bytes, last,
      input  ready
   );
   modport sink (
      input  valid, status, complete, out_data, out_bytes, last,
      output ready
   );
endinterface

// ===== hdl/chunked_message_reassembly.sv =====
// A put or query result passes the held beat register, the work queue and the output
// register; a take also reads each chunk from the chunk store before it is shown.
// Throughput: the front takes one beat per cycle unless the work queue is full; the back
// emits one result beat per cycle while results are taken, and pops no work during a take.
// Reset clears the slot valid bits, the work queue and the output valid bit at once.
module chunked_message_reassembly import cmr_pkg::*; #(
   parameter int SLOTS       = 8,
   parameter int MAX_CHUNKS  = 16,
   parameter int CHUNK_BYTES = 8
) (
   input  logic       clock,
   input  logic       reset,
   cmr_req_if.sink    req_chan,
   cmr_rsp_if.source  rsp_chan
);

   cmr_op_type front_op;
   cmr_op_type back_op;
   logic       q_push;
   logic       q_full;
   logic       q_pop;
   logic       q_not_empty;

   cmr_front #(
      .SLOTS       (SLOTS),
      .MAX_CHUNKS  (MAX_CHUNKS),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .op       (front_op),
      .op_push  (q_push),
      .op_full  (q_full)
   );

   cmr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_op   (front_op),
      .full      (q_full),
      .pop       (q_pop),
      .pop_op    (back_op),
      .not_empty (q_not_empty)
   );

   cmr_back #(
      .SLOTS       (SLOTS),
      .MAX_CHUNKS  (MAX_CHUNKS),
      .CHUNK_BYTES (CHUNK_BYTES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .op       (back_op),
      .op_valid (q_not_empty),
      .op_pop   (q_pop),
      .rsp_chan (rsp_chan)
   );

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("result beat valid right after reset");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("work queue written while full");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("work queue read while empty");

   a_inner_beat_is_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.last) |-> (rsp_chan.status == ST_OK && rsp_chan.complete))
      else $error("non-final result beat that is not a take chunk");

endmodule

// ===== hdl/cmr_ram.sv =====
module cmr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/cmr_queue.sv =====
module cmr_queue import cmr_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  cmr_op_type push_op,
   output logic       full,
   input  logic       pop,
   output cmr_op_type pop_op,
   output logic       not_empty
);

   localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   cmr_op_type    entry_ff [QUEUE_DEPTH];
   cmr_op_type    entry_in [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = push_op;
         wr_ptr_in = (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_op    = entry_ff[rd_ptr_ff];

endmodule

// ===== hdl/cmr_front.sv =====
module cmr_front import cmr_pkg::*; #(
   parameter int SLOTS       = 8,
   parameter int MAX_CHUNKS  = 16,
   parameter int CHUNK_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   cmr_req_if.sink     req_chan,
   output cmr_op_type  op,
   output logic        op_push,
   input  logic        op_full
);

   localparam int NCH = (MAX_CHUNKS > INDEX_CHUNKS) ? INDEX_CHUNKS : MAX_CHUNKS;
   localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DW  = 8 * CHUNK_BYTES;

   logic               hold_ff, hold_in;
   cmr_item_type       item_ff, item_in;
   logic [SLOTS-1:0]   valid_ff, valid_in;
   logic [ID_W-1:0]    id_ff    [SLOTS];
   logic [ID_W-1:0]    id_in    [SLOTS];
   logic [TOTAL_W-1:0] total_ff [SLOTS];
   logic [TOTAL_W-1:0] total_in [SLOTS];
   logic [NCH-1:0]     map_ff   [SLOTS];
   logic [NCH-1:0]     map_in   [SLOTS];
   logic [TOTAL_W-1:0] count_ff [SLOTS];
   logic [TOTAL_W-1:0] count_in [SLOTS];

   logic               req_fire;
   logic               step_done;
   logic               cmd_known;
   logic               is_put;
   logic               is_take;
   logic [SLOTS-1:0]   match;
   logic [SLOTS-1:0]   free;
   logic [SLOTS-1:0]   low_free;
   logic [SLOTS-1:0]   sel;
   logic               hit;
   logic               any_free;
   logic [SW-1:0]      sel_slot;
   logic [TOTAL_W-1:0] sel_total;
   logic [NCH-1:0]     sel_map;
   logic [TOTAL_W-1:0] sel_count;
   logic [NCH-1:0]     map_shift;
   logic [NCH-1:0]     base_map;
   logic [NCH-1:0]     new_map;
   logic [TOTAL_W-1:0] base_count;
   logic [TOTAL_W-1:0] new_count;
   logic               bit_old;
   logic               range_err;
   logic               put_ok;
   logic               slot_done;
   logic [STATUS_W-1:0] put_status;
   logic [BYTES_W-1:0] bytes_sat;
   logic [DW-1:0]      data_masked;

   assign req_fire       = req_chan.valid && req_chan.ready;
   assign cmd_known      = (item_ff.command == CMD_PUT) || (item_ff.command == CMD_QUERY) ||
                           (item_ff.command == CMD_TAKE);
   assign is_put         = (item_ff.command == CMD_PUT);
   assign is_take        = (item_ff.command == CMD_TAKE);
   assign step_done      = hold_ff && (!op_full || !cmd_known);
   assign op_push        = hold_ff && cmd_known && !op_full;
   assign req_chan.ready = !hold_ff || step_done;

   // Slot lookup: every slot compares its id against the held beat at once.
   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         match[s] = valid_ff[s] && (id_ff[s] == item_ff.msg_id);
      end
   end

   assign free     = ~valid_ff;
   assign low_free = free & (~free + 1'b1);
   assign hit      = |match;
   assign any_free = |free;
   assign sel      = hit ? match : low_free;

   always_comb begin
      sel_slot  = '0;
      sel_total = '0;
      sel_map   = '0;
      sel_count = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (sel[s]) begin
            sel_slot = sel_slot | SW'(s);
         end
         sel_total = sel_total | (total_ff[s] & {TOTAL_W{sel[s]}});
         sel_map   = sel_map   | (map_ff[s]   & {NCH{sel[s]}});
         sel_count = sel_count | (count_ff[s] & {TOTAL_W{sel[s]}});
      end
   end

   assign base_map   = hit ? sel_map : '0;
   assign base_count = hit ? sel_count : '0;
   assign map_shift  = base_map >> item_ff.chunk_index;
   assign bit_old    = map_shift[0];
   assign new_map    = base_map | (NCH'(1) << item_ff.chunk_index);
   assign new_count  = bit_old ? base_count : base_count + 1'b1;

   assign range_err = ({1'b0, item_ff.chunk_index} >= item_ff.chunk_total) ||
                      (int'(item_ff.chunk_total) > MAX_CHUNKS);
   assign put_ok    = (item_ff.chunk_total != '0) && !range_err &&
                      (hit ? (sel_total == item_ff.chunk_total) : any_free);
   assign slot_done = hit && (sel_total != '0) && (sel_count == sel_total);

   always_comb begin
      priority if (item_ff.chunk_total == '0) begin
         put_status = ST_ZERO_TOTAL;
      end else if (range_err) begin
         put_status = ST_RANGE;
      end else if (hit && (sel_total != item_ff.chunk_total)) begin
         put_status = ST_MISMATCH;
      end else if (!hit && !any_free) begin
         put_status = ST_FULL;
      end else begin
         put_status = ST_OK;
      end
   end

   // Byte counts above the chunk size saturate; bytes past the count store as zero.
   assign bytes_sat = (int'(item_ff.chunk_bytes) > CHUNK_BYTES) ? BYTES_W'(CHUNK_BYTES)
                                                                 : item_ff.chunk_bytes;

   always_comb begin
      for (int b = 0; b < CHUNK_BYTES; b++) begin
         data_masked[8*b +: 8] = (b < int'(bytes_sat)) ? item_ff.chunk_data[8*b +: 8] : 8'h00;
      end
   end

   always_comb begin
      op          = '0;
      op.slot     = SLOT_FIELD_W'(sel_slot);
      op.index    = item_ff.chunk_index;
      op.total    = sel_total;
      op.data     = DATA_W'(data_masked);
      op.bytes    = bytes_sat;
      op.kind     = OP_RESP;
      unique case (item_ff.command)
         CMD_PUT: begin
            op.status   = put_status;
            op.complete = put_ok && (new_count == item_ff.chunk_total);
            op.kind     = (put_ok && !bit_old) ? OP_WRITE : OP_RESP;
         end
         CMD_QUERY: begin
            op.status   = ST_OK;
            op.complete = slot_done;
         end
         CMD_TAKE: begin
            if (!hit) begin
               op.status = ST_NOT_FOUND;
            end else if (!slot_done) begin
               op.status = ST_NOT_COMPLETE;
            end else begin
               op.status = ST_OK;
               op.kind   = OP_TAKE;
            end
         end
         default: begin
            op.status = ST_OK;
         end
      endcase
   end

   always_comb begin
      hold_in  = req_fire ? 1'b1 : (step_done ? 1'b0 : hold_ff);
      item_in  = item_ff;
      if (req_fire) begin
         item_in.command     = req_chan.command;
         item_in.msg_id      = req_chan.msg_id;
         item_in.chunk_index = req_chan.chunk_index;
         item_in.chunk_total = req_chan.chunk_total;
         item_in.chunk_data  = req_chan.chunk_data;
         item_in.chunk_bytes = req_chan.chunk_bytes;
      end
      valid_in = valid_ff;
      id_in    = id_ff;
      total_in = total_ff;
      map_in   = map_ff;
      count_in = count_ff;
      if (step_done && is_put && put_ok) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (sel[s]) begin
               valid_in[s] = 1'b1;
               if (!hit) begin
                  id_in[s]    = item_ff.msg_id;
                  total_in[s] = item_ff.chunk_total;
               end
               map_in[s]   = new_map;
               count_in[s] = new_count;
            end
         end
      end
      // A take that will drain the message frees its slot right away.
      if (step_done && is_take && slot_done) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (match[s]) begin
               valid_in[s] = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff  <= 1'b0;
         valid_ff <= '0;
      end else begin
         hold_ff  <= hold_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      id_ff    <= id_in;
      total_ff <= total_in;
      map_ff   <= map_in;
      count_ff <= count_in;
   end

endmodule

// ===== hdl/cmr_back.sv =====
module cmr_back import cmr_pkg::*; #(
   parameter int SLOTS       = 8,
   parameter int MAX_CHUNKS  = 16,
   parameter int CHUNK_BYTES = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  cmr_op_type  op,
   input  logic        op_valid,
   output logic        op_pop,
   cmr_rsp_if.source   rsp_chan
);

   localparam int NCH   = (MAX_CHUNKS > INDEX_CHUNKS) ? INDEX_CHUNKS : MAX_CHUNKS;
   localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int IW    = (NCH > 1) ? $clog2(NCH) : 1;
   localparam int DW    = 8 * CHUNK_BYTES;
   localparam int AW    = SW + IW;
   localparam int DEPTH = 1 << AW;
   localparam int RW    = DW + BYTES_W;

   localparam logic BS_IDLE = 1'b0;
   localparam logic BS_TAKE = 1'b1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                complete;
      logic [DATA_W-1:0]   out_data;
      logic [BYTES_W-1:0]  out_bytes;
      logic                last;
   } cmr_rsp_type;

   logic               st_ff, st_in;
   logic [TOTAL_W-1:0] cnt_ff, cnt_in;
   logic [SW-1:0]      slot_ff, slot_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               out_valid_ff, out_valid_in;
   cmr_rsp_type        out_ff, out_in;

   logic               out_free;
   logic [TOTAL_W-1:0] cnt_nx;
   logic               take_last;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic [RW-1:0]      rd_data;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign cnt_nx    = cnt_ff + 1'b1;
   assign take_last = (cnt_nx == total_ff);
   assign op_pop    = (st_ff == BS_IDLE) && op_valid && out_free;
   assign wr_addr   = {op.slot[SW-1:0], op.index[IW-1:0]};
   assign wr_en     = op_pop && (op.kind == OP_WRITE);

   always_comb begin
      st_in        = st_ff;
      cnt_in       = cnt_ff;
      slot_in      = slot_ff;
      total_in     = total_ff;
      out_valid_in = out_valid_ff && !rsp_chan.ready;
      out_in       = out_ff;
      rd_en        = 1'b0;
      rd_addr      = {slot_ff, cnt_nx[IW-1:0]};
      unique case (st_ff)
         BS_IDLE: begin
            if (op_pop) begin
               unique case (op.kind)
                  OP_RESP, OP_WRITE: begin
                     out_valid_in     = 1'b1;
                     out_in.status    = op.status;
                     out_in.complete  = op.complete;
                     out_in.out_data  = '0;
                     out_in.out_bytes = '0;
                     out_in.last      = 1'b1;
                  end
                  OP_TAKE: begin
                     // The first chunk is read now and shown once the read data is registered and the output is free.
                     rd_en    = 1'b1;
                     rd_addr  = {op.slot[SW-1:0], {IW{1'b0}}};
                     cnt_in   = '0;
                     slot_in  = op.slot[SW-1:0];
                     total_in = op.total;
                     st_in    = BS_TAKE;
                  end
                  default: begin
                     out_valid_in = out_valid_ff && !rsp_chan.ready;
                  end
               endcase
            end
         end
         BS_TAKE: begin
            if (out_free) begin
               out_valid_in     = 1'b1;
               out_in.status    = ST_OK;
               out_in.complete  = 1'b1;
               out_in.out_data  = DATA_W'(rd_data[DW-1:0]);
               out_in.out_bytes = rd_data[RW-1:DW];
               out_in.last      = take_last;
               if (take_last) begin
                  st_in = BS_IDLE;
               end else begin
                  cnt_in = cnt_nx;
                  rd_en  = 1'b1;
               end
            end
         end
         default: begin
            st_in = BS_IDLE;
         end
      endcase
   end

   cmr_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data ({op.bytes, op.data[DW-1:0]}),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= BS_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff   <= cnt_in;
      slot_ff  <= slot_in;
      total_ff <= total_in;
      out_ff   <= out_in;
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.status    = out_ff.status;
   assign rsp_chan.complete  = out_ff.complete;
   assign rsp_chan.out_data  = out_ff.out_data;
   assign rsp_chan.out_bytes = out_ff.out_bytes;
   assign rsp_chan.last      = out_ff.last;

endmodule

// ===== bench/testbench.sv =====
module testbench import cmr_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOTS       = 8;
   localparam int MAX_CHUNKS  = 16;
   localparam int CHUNK_BYTES = 8;

   localparam int HOLD_CYCLES   = 300;
   localparam int RANDOM_ITEMS  = 35;
   localparam int REPORT_LIMIT  = 10;

   // Command code that the block has no use for.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam logic [ID_W-1:0]   LONG_ID   = '1;
   localparam logic [DATA_W-1:0] ALL_ONES  = '1;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                complete;
      logic [DATA_W-1:0]   data;
      logic [BYTES_W-1:0]  bytes;
      logic                last;
   } reply_type;

   typedef int index_list_type [$];

   logic clock;
   logic reset;

   cmr_req_if req_chan ();
   cmr_rsp_if rsp_chan ();

   chunked_message_reassembly #(
      .SLOTS(SLOTS),
      .MAX_CHUNKS(MAX_CHUNKS),
      .CHUNK_BYTES(CHUNK_BYTES)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // Table as the block should hold it.
   logic                    slot_busy  [SLOTS];
   logic [ID_W-1:0]         slot_key   [SLOTS];
   logic [TOTAL_W-1:0]      slot_size  [SLOTS];
   logic [INDEX_CHUNKS-1:0] slot_seen  [SLOTS];
   logic [TOTAL_W-1:0]      slot_have  [SLOTS];
   logic [DATA_W-1:0]       chunk_word [SLOTS][MAX_CHUNKS];
   logic [BYTES_W-1:0]      chunk_len  [SLOTS][MAX_CHUNKS];

   cmr_item_type request_q [$];
   reply_type    awaited_replies [$];

   int  items_sent = 0;
   int  mismatch_count = 0;
   int  burst_left = 4;
   int  gap_left = 0;
   bit  send_back_to_back = 1'b0;
   bit  hold_request = 1'b0;
   int  hold_left = 0;
   logic [7:0] stall_phase = '0;
   logic [ID_W-1:0] last_taken_id = '0;

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   function automatic int lookup_slot(logic [ID_W-1:0] id);
      for (int s = 0; s < SLOTS; s++)
         if (slot_busy[s] && slot_key[s] == id) return s;
      return -1;
   endfunction

   function automatic void expect_reply(logic [STATUS_W-1:0] status, logic complete,
                                        logic [DATA_W-1:0] data, logic [BYTES_W-1:0] bytes,
                                        logic last);
      awaited_replies.push_back('{status, complete, data, bytes, last});
   endfunction

   function automatic void predict_replies(cmr_item_type it);
      int s;
      logic [BYTES_W-1:0] len;
      logic [DATA_W-1:0]  kept;
      s = lookup_slot(it.msg_id);
      case (it.command)
         CMD_PUT: begin
            if (it.chunk_total == 0) begin
               expect_reply(ST_ZERO_TOTAL, 1'b0, '0, '0, 1'b1);
               return;
            end
            if (it.chunk_index >= it.chunk_total || it.chunk_total > MAX_CHUNKS) begin
               expect_reply(ST_RANGE, 1'b0, '0, '0, 1'b1);
               return;
            end
            if (s < 0) begin
               for (int f = 0; f < SLOTS && s < 0; f++)
                  if (!slot_busy[f]) s = f;
               if (s < 0) begin
                  expect_reply(ST_FULL, 1'b0, '0, '0, 1'b1);
                  return;
               end
               slot_busy[s] = 1'b1;
               slot_key[s]  = it.msg_id;
               slot_size[s] = it.chunk_total;
               slot_seen[s] = '0;
               slot_have[s] = '0;
            end else if (slot_size[s] != it.chunk_total) begin
               expect_reply(ST_MISMATCH, 1'b0, '0, '0, 1'b1);
               return;
            end
            // A repeated index keeps whatever arrived first.
            if (!slot_seen[s][it.chunk_index]) begin
               len = (it.chunk_bytes > CHUNK_BYTES) ? BYTES_W'(CHUNK_BYTES) : it.chunk_bytes;
               kept = it.chunk_data;
               for (int b = 0; b < 8; b++)
                  if (b >= len) kept[8*b +: 8] = '0;
               chunk_word[s][it.chunk_index] = kept;
               chunk_len[s][it.chunk_index] = len;
               slot_seen[s][it.chunk_index] = 1'b1;
               slot_have[s] = slot_have[s] + 1'b1;
            end
            expect_reply(ST_OK, slot_have[s] == slot_size[s], '0, '0, 1'b1);
         end
         CMD_QUERY: begin
            expect_reply(ST_OK, (s >= 0) ? (slot_have[s] == slot_size[s]) : 1'b0,
                         '0, '0, 1'b1);
         end
         CMD_TAKE: begin
            if (s < 0) begin
               expect_reply(ST_NOT_FOUND, 1'b0, '0, '0, 1'b1);
            end else if (slot_have[s] != slot_size[s]) begin
               expect_reply(ST_NOT_COMPLETE, 1'b0, '0, '0, 1'b1);
            end else begin
               for (int i = 0; i < slot_size[s]; i++)
                  expect_reply(ST_OK, 1'b1, chunk_word[s][i], chunk_len[s][i],
                               i == slot_size[s] - 1);
               slot_busy[s] = 1'b0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Request driver: one beat per handshake, in bursts with gaps between them.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predict_replies(request_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = (send_back_to_back || $urandom_range(0, 2) == 0) ?
                          0 : $urandom_range(1, 6);
            end
         end else if (gap_left != 0) begin
            gap_left--;
         end
         if (request_q.size() != 0 && gap_left == 0) begin
            req_chan.valid       <= 1'b1;
            req_chan.command     <= request_q[0].command;
            req_chan.msg_id      <= request_q[0].msg_id;
            req_chan.chunk_index <= request_q[0].chunk_index;
            req_chan.chunk_total <= request_q[0].chunk_total;
            req_chan.chunk_data  <= request_q[0].chunk_data;
            req_chan.chunk_bytes <= request_q[0].chunk_bytes;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Result side stalls on a pattern chosen by the upper bits of a phase counter.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_request || hold_left != 0) begin
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end else begin
            hold_left--;
         end
         rsp_chan.ready <= 1'b0;
      end else begin
         stall_phase = stall_phase + 1'b1;
         case (stall_phase[7:6])
            2'd0: rsp_chan.ready <= 1'b1;
            2'd1: rsp_chan.ready <= (stall_phase[1:0] != 2'd0);
            2'd2: rsp_chan.ready <= 1'($urandom_range(0, 1));
            default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   task automatic note_mismatch(string what, reply_type want, reply_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch, %s: expected status %0d complete %0b data %h bytes %0d last %0b,",
                  what, want.status, want.complete, want.data, want.bytes, want.last,
                  " got status %0d complete %0b data %h bytes %0d last %0b",
                  got.status, got.complete, got.data, got.bytes, got.last);
   endtask

   always @(posedge clock) begin
      reply_type got;
      reply_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{rsp_chan.status, rsp_chan.complete, rsp_chan.out_data, rsp_chan.out_bytes,
                 rsp_chan.last};
         if (awaited_replies.size() == 0) begin
            note_mismatch("result beat with nothing outstanding", '0, got);
         end else begin
            want = awaited_replies.pop_front();
            if (got.status !== want.status || got.complete !== want.complete ||
                got.data !== want.data || got.bytes !== want.bytes || got.last !== want.last)
               note_mismatch("result beat", want, got);
         end
      end
   end

   function automatic logic [DATA_W-1:0] random_word();
      return {$urandom, $urandom};
   endfunction

   function automatic cmr_item_type make_request(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id,
                                                 int idx, int total,
                                                 logic [DATA_W-1:0] data, int bytes);
      cmr_item_type it;
      it.command     = cmd;
      it.msg_id      = id;
      it.chunk_index = IDX_W'(idx);
      it.chunk_total = TOTAL_W'(total);
      it.chunk_data  = data;
      it.chunk_bytes = BYTES_W'(bytes);
      return it;
   endfunction

   // Random command on an unknown id; a put is always one that must be rejected.
   function automatic cmr_item_type noise_request();
      logic [CMD_W-1:0] cmd;
      int idx;
      int total;
      cmd = CMD_W'($urandom_range(0, 3));
      idx = $urandom_range(0, 15);
      total = $urandom_range(0, 31);
      if (cmd == CMD_PUT && total != 0 && idx < total && total <= MAX_CHUNKS)
         total = idx;
      return make_request(cmd, random_word(), idx, total, random_word(),
                          $urandom_range(0, 15));
   endfunction

   function automatic index_list_type shuffled_indices(int count);
      index_list_type order;
      int j;
      int swap;
      for (int i = 0; i < count; i++) order.push_back(i);
      for (int i = count - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap = order[i];
         order[i] = order[j];
         order[j] = swap;
      end
      return order;
   endfunction

   task automatic send_request(cmr_item_type it);
      request_q.push_back(it);
      items_sent++;
   endtask

   task automatic wait_idle();
      while (request_q.size() != 0 || awaited_replies.size() != 0) @(posedge clock);
   endtask

   // Several messages interleaved beat by beat, plus a little noise.
   task automatic run_message_round(int messages);
      cmr_item_type   plans [4][$];
      index_list_type order;
      logic [ID_W-1:0] id;
      int total;
      int drop;
      int wrong_total;
      int live;
      int pick;
      for (int m = 0; m < messages; m++) begin
         // An id freed by a take may be claimed again.
         id = (m == 0 && $urandom_range(0, 5) == 0) ? last_taken_id : random_word();
         total = ($urandom_range(0, 7) == 0) ? $urandom_range(9, MAX_CHUNKS) :
                 $urandom_range(1, 4);
         drop = (total > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(0, total - 1) : -1;
         order = shuffled_indices(total);
         for (int k = 0; k < total; k++) begin
            if (order[k] != drop) begin
               plans[m].push_back(make_request(CMD_PUT, id, order[k], total, random_word(),
                                               $urandom_range(0, 15)));
               if ($urandom_range(0, 9) == 0)
                  plans[m].push_back(make_request(CMD_PUT, id, order[k], total,
                                                  random_word(), $urandom_range(0, 15)));
               if ($urandom_range(0, 4) == 0)
                  plans[m].push_back(make_request(CMD_QUERY, id, 0, 0, '0, 0));
               if (k == 0 && $urandom_range(0, 5) == 0) begin
                  wrong_total = (total == MAX_CHUNKS) ? total - 1 : total + 1;
                  plans[m].push_back(make_request(CMD_PUT, id,
                                                  $urandom_range(0, wrong_total - 1),
                                                  wrong_total, random_word(), 8));
               end
            end
         end
         // A message with a missing chunk is taken too early, then repaired.
         if (drop >= 0) begin
            plans[m].push_back(make_request(CMD_TAKE, id, 0, 0, '0, 0));
            plans[m].push_back(make_request(CMD_PUT, id, drop, total, random_word(),
                                            $urandom_range(0, 15)));
         end
         if ($urandom_range(0, 1) == 1)
            plans[m].push_back(make_request(CMD_QUERY, id, 0, 0, '0, 0));
         plans[m].push_back(make_request(CMD_TAKE, id, 0, 0, '0, 0));
         last_taken_id = id;
      end
      for (int n = $urandom_range(0, 2); n > 0; n--)
         plans[3].push_back(noise_request());
      do begin
         live = 0;
         for (int p = 0; p < 4; p++)
            if (plans[p].size() != 0) live++;
         if (live != 0) begin
            pick = $urandom_range(0, live - 1);
            for (int p = 0; p < 4; p++) begin
               if (plans[p].size() != 0) begin
                  if (pick == 0) send_request(plans[p].pop_front());
                  pick--;
               end
            end
         end
      end while (live != 0);
   endtask

   task automatic test_status_codes();
      send_request(make_request(CMD_TAKE, LONG_ID, 0, 0, '0, 0));
      send_request(make_request(CMD_QUERY, LONG_ID, 0, 0, '0, 0));
      send_request(make_request(CMD_PUT, random_word(), 0, 0, random_word(), 8));
      send_request(make_request(CMD_PUT, random_word(), 5, 5, random_word(), 8));
      send_request(make_request(CMD_PUT, random_word(), 0, MAX_CHUNKS + 1, random_word(), 8));
      send_request(make_request(CMD_UNUSED, LONG_ID, 15, 31, ALL_ONES, 15));
      send_request(make_request(CMD_PUT, LONG_ID, 15, MAX_CHUNKS, ALL_ONES, 15));
      send_request(make_request(CMD_PUT, LONG_ID, 0, 3, random_word(), 8));
      send_request(make_request(CMD_TAKE, LONG_ID, 0, 0, '0, 0));
      send_request(make_request(CMD_PUT, LONG_ID, 15, MAX_CHUNKS, '0, 3));
      wait_idle();
   endtask

   // The long message holds one slot; seven single-chunk messages take the rest.
   task automatic test_table_full();
      logic [ID_W-1:0] ids [SLOTS-1];
      for (int i = 0; i < SLOTS - 1; i++) begin
         ids[i] = (i == 0) ? '0 : random_word();
         send_request(make_request(CMD_PUT, ids[i], 0, 1, ALL_ONES, i));
      end
      send_request(make_request(CMD_PUT, random_word(), 0, 1, random_word(), 8));
      send_request(make_request(CMD_QUERY, ids[0], 0, 0, '0, 0));
      for (int i = 0; i < SLOTS - 1; i++)
         send_request(make_request(CMD_TAKE, ids[i], 0, 0, '0, 0));
      wait_idle();
   endtask

   task automatic test_full_length_message();
      index_list_type order;
      order = shuffled_indices(MAX_CHUNKS - 1);
      foreach (order[k])
         send_request(make_request(CMD_PUT, LONG_ID, order[k], MAX_CHUNKS, random_word(),
                                   $urandom_range(0, 15)));
      send_request(make_request(CMD_QUERY, LONG_ID, 0, 0, '0, 0));
      send_request(make_request(CMD_TAKE, LONG_ID, 0, 0, '0, 0));
      wait_idle();
   endtask

   // Results are held off while the sender keeps offering beats.
   task automatic test_backpressure();
      send_back_to_back = 1'b1;
      hold_request = 1'b1;
      run_message_round(3);
      wait_idle();
      send_back_to_back = 1'b0;
   endtask

   task automatic test_random_traffic();
      int start;
      start = items_sent;
      while (items_sent - start < RANDOM_ITEMS) begin
         run_message_round($urandom_range(1, 3));
         if ($urandom_range(0, 7) == 0) wait_idle();
      end
   endtask

   initial begin
      int n;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.command = CMD_PUT;
      req_chan.msg_id = '0;
      req_chan.chunk_index = '0;
      req_chan.chunk_total = '0;
      req_chan.chunk_data = '0;
      req_chan.chunk_bytes = '0;
      rsp_chan.ready = 1'b0;
      for (int s = 0; s < SLOTS; s++) slot_busy[s] = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_status_codes();
      test_table_full();
      test_full_length_message();
      test_backpressure();
      test_random_traffic();

      while (request_q.size() != 0) @(posedge clock);
      for (n = 0; n < 20000 && awaited_replies.size() != 0; n++) @(posedge clock);
      repeat (20) @(posedge clock);
      if (awaited_replies.size() != 0) begin
         mismatch_count++;
         $display("%0d expected result beats never arrived", awaited_replies.size());
      end
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
